FILE: rtl/rtbs_pkg.sv
package rtbs_pkg;

  // input opcodes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // one stored table entry: inclusive key range and its value
  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] value;
  } entry_t;

  // search sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

endpackage

FILE: rtl/rtbs_table.sv
module rtbs_table
  import rtbs_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/range_table_binary_search_unit.sv
// append, clear and unused opcodes: result is in the output register in the cycle after the beat
// query: each probe reads the middle table entry, then compares it with the key, for up to
//   floor(log2(count))+1 probes; a miss ends on an empty window, and the result is then
//   loaded into the output register once that register is free
// one item at a time; the next beat is taken once the sequencer is idle and the output register is free
// reset clears the entry count, the sequencer and the output valid; table is never read unwritten
module range_table_binary_search_unit
  import rtbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] range_start,
  input  logic [15:0] range_end,
  input  logic [15:0] range_value,
  input  logic [15:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] found_value
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] low, low_next;
  logic [CW-1:0] hp1, hp1_next;   // one past the top of the search window
  logic [15:0]   key_q;
  logic [1:0]    res_status, res_status_next;
  logic [15:0]   res_value, res_value_next;
  logic          out_valid_next;
  logic [1:0]    status_next;
  logic [15:0]   found_value_next;

  logic          in_fire;
  logic          out_free;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic          wr_en;
  logic          rd_en;
  entry_t        wr_data;
  entry_t        rd_data;
  logic          hit;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  // probe point: floor((low + high) / 2) with high = hp1 - 1
  assign mid_sum = {1'b0, low} + {1'b0, hp1} - {{CW{1'b0}}, 1'b1};
  assign mid     = mid_sum[CW:1];

  assign wr_data = '{lo: range_start, hi: range_end, value: range_value};
  assign hit     = (rd_data.lo <= key_q) && (rd_data.hi >= key_q);

  rtbs_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (mid[AW-1:0]),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // search window, latched key and result payload
  always_ff @(posedge clk) begin
    low         <= low_next;
    hp1         <= hp1_next;
    res_status  <= res_status_next;
    res_value   <= res_value_next;
    status      <= status_next;
    found_value <= found_value_next;
    if (in_fire) begin
      key_q <= key;
    end
  end

  // sequencer
  always_comb begin
    state_next       = state;
    count_next       = count;
    low_next         = low;
    hp1_next         = hp1;
    res_status_next  = res_status;
    res_value_next   = res_value;
    out_valid_next   = out_valid && !out_ready;
    status_next      = status;
    found_value_next = found_value;
    wr_en            = 1'b0;
    rd_en            = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (opcode)
            OP_APPEND: begin
              out_valid_next   = 1'b1;
              found_value_next = '0;
              if (count == FULL_COUNT) begin
                status_next = ST_FULL;
              end else begin
                status_next = ST_OK;
                wr_en       = 1'b1;
                count_next  = count + 1'b1;
              end
            end
            OP_QUERY: begin
              low_next   = '0;
              hp1_next   = count;
              state_next = S_PROBE;
            end
            OP_CLEAR: begin
              count_next       = '0;
              out_valid_next   = 1'b1;
              status_next      = ST_OK;
              found_value_next = '0;
            end
            default: begin
              out_valid_next   = 1'b1;
              status_next      = ST_OK;
              found_value_next = '0;
            end
          endcase
        end
      end

      // read the middle entry, or stop on an empty window
      S_PROBE: begin
        if (low < hp1) begin
          rd_en      = 1'b1;
          state_next = S_CMP;
        end else begin
          res_status_next = ST_NOT_FOUND;
          res_value_next  = '0;
          state_next      = S_DONE;
        end
      end

      // compare key against the entry and narrow the window
      S_CMP: begin
        if (hit) begin
          res_status_next = ST_OK;
          res_value_next  = rd_data.value;
          state_next      = S_DONE;
        end else begin
          if (key_q < rd_data.lo) begin
            hp1_next = mid;
          end else begin
            low_next = mid + 1'b1;
          end
          state_next = S_PROBE;
        end
      end

      // hand the query result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          status_next      = res_status;
          found_value_next = res_value;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rtbs_checker.sv
module rtbs_checker
  import rtbs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] found_value
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_value))
    else $error("result beat changed while stalled");

  // a not found or full result carries a zero value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> found_value == 16'd0)
    else $error("nonzero value on a not found or full result");

  // non-query beats produce their result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode != OP_QUERY |=> out_valid)
    else $error("missing result after append or clear");

  // a query occupies the block while it searches
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_QUERY |=> !in_ready)
    else $error("input taken during a search");

  // only defined status codes are produced
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NOT_FOUND || status == ST_FULL))
    else $error("invalid status code");

endmodule

bind range_table_binary_search_unit rtbs_checker u_rtbs_checker (.*);

FILE: tb/tb_range_table_binary_search_unit.sv
module tb_range_table_binary_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rtbs_pkg::*;

  localparam int TBL_DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] rstart;
    logic [15:0] rend;
    logic [15:0] rvalue;
    logic [15:0] qkey;
  } table_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_APPEND;
  logic [15:0] range_start = '0;
  logic [15:0] range_end = '0;
  logic [15:0] range_value = '0;
  logic [15:0] key = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] found_value;

  // commands waiting to be driven and results waiting to come back
  table_cmd_t     pending_cmds[$];
  lookup_result_t lookup_results_q[$];

  // shadow copy of the range table
  logic [15:0] tbl_lo[TBL_DEPTH];
  logic [15:0] tbl_hi[TBL_DEPTH];
  logic [15:0] tbl_val[TBL_DEPTH];
  int          tbl_count = 0;

  // ranges of the session being generated, used to aim query keys
  int sess_lo[$];
  int sess_hi[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_left = 0;
  int  phase_items = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;
  table_cmd_t cur_cmd;

  range_table_binary_search_unit #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .range_start(range_start),
    .range_end  (range_end),
    .range_value(range_value),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found_value(found_value)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one command to the shadow table and return its result
  function automatic lookup_result_t table_op_result(input logic [1:0] op,
                                                     input logic [15:0] rs,
                                                     input logic [15:0] re,
                                                     input logic [15:0] rv,
                                                     input logic [15:0] k);
    lookup_result_t r;
    int lo_i;
    int hi_i;
    int mid;
    bit hit;
    r.status = ST_OK;
    r.value = '0;
    case (op)
      OP_APPEND: begin
        if (tbl_count >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_lo[tbl_count] = rs;
          tbl_hi[tbl_count] = re;
          tbl_val[tbl_count] = rv;
          tbl_count++;
        end
      end
      OP_QUERY: begin
        // binary search over the loaded entries, probe order as in hardware
        hit = 1'b0;
        lo_i = 0;
        hi_i = tbl_count - 1;
        while (lo_i <= hi_i && !hit) begin
          mid = lo_i + (hi_i - lo_i) / 2;
          if (tbl_lo[mid] <= k && k <= tbl_hi[mid]) begin
            hit = 1'b1;
            r.value = tbl_val[mid];
          end else if (k < tbl_lo[mid]) begin
            hi_i = mid - 1;
          end else begin
            lo_i = mid + 1;
          end
        end
        if (!hit) begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        tbl_count = 0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void push_cmd(input logic [1:0] op, input logic [15:0] rs,
                                   input logic [15:0] re, input logic [15:0] rv,
                                   input logic [15:0] k);
    table_cmd_t c;
    c.op = op;
    c.rstart = rs;
    c.rend = re;
    c.rvalue = rv;
    c.qkey = k;
    pending_cmds.push_back(c);
    phase_items++;
  endfunction

  // key aimed at the edges and insides of the current session's ranges, just outside them, the key extremes, or random
  function automatic logic [15:0] pick_key();
    int i;
    int s;
    int e;
    if (sess_lo.size() == 0) begin
      return 16'($urandom);
    end
    i = $urandom_range(sess_lo.size() - 1);
    s = sess_lo[i];
    e = sess_hi[i];
    case ($urandom_range(6))
      0: return 16'($urandom_range(e, s));
      1: return 16'(s);
      2: return 16'(e);
      3: return 16'((s > 0) ? s - 1 : 0);
      4: return 16'((e < 65535) ? e + 1 : 65535);
      5: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // clear, then ascending non-overlapping appends mixed with queries
  task automatic add_session(input int n_entries, input int n_over);
    int span;
    int cursor;
    int s;
    int e;
    int nq;
    span = 65536 / (n_entries + 1);
    cursor = $urandom_range(span / 4);
    sess_lo.delete();
    sess_hi.delete();
    push_cmd(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < n_entries + n_over; i++) begin
      s = cursor + $urandom_range(span / 4);
      e = s + $urandom_range(span / 2);
      if (e > 65535) begin
        e = 65535;
      end
      if (s > 65535) begin
        s = 65535;
      end
      cursor = e + 1;
      push_cmd(OP_APPEND, 16'(s), 16'(e), 16'($urandom), 16'($urandom));
      if (i < n_entries) begin
        sess_lo.push_back(s);
        sess_hi.push_back(e);
      end
      if ($urandom_range(99) < 30) begin
        push_cmd(OP_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), pick_key());
      end
    end
    nq = $urandom_range(12, 3);
    for (int i = 0; i < nq; i++) begin
      push_cmd(OP_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), pick_key());
    end
  endtask

  // short burst of arbitrary commands, unsorted appends and unused opcodes
  task automatic add_noise();
    int n;
    n = $urandom_range(8, 3);
    for (int i = 0; i < n; i++) begin
      push_cmd(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || lookup_results_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // input beat: predict the result of the accepted command
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      in_taken = 1'b1;
      lookup_results_q.push_back(table_op_result(opcode, range_start, range_end,
                                                 range_value, key));
    end
  end

  // driver: hold the beat until taken, then load the next one or idle
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        opcode <= cur_cmd.op;
        range_start <= cur_cmd.rstart;
        range_end <= cur_cmd.rend;
        range_value <= cur_cmd.rvalue;
        key <= cur_cmd.qkey;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compare each output beat with the oldest prediction
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (lookup_results_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status %0d found_value %h", $time, status,
                 found_value);
      end else begin
        exp_r = lookup_results_q.pop_front();
        if (status !== exp_r.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
        end
        if (found_value !== exp_r.value) begin
          error_count++;
          $display("%0t: found_value expected %h actual %h", $time, exp_r.value,
                   found_value);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, field extremes, reversed range, edges, clear
    push_cmd(OP_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    push_cmd(OP_APPEND, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_APPEND, 16'd10, 16'd20, 16'h1234, 16'h0000);
    push_cmd(OP_APPEND, 16'd30, 16'd25, 16'hAAAA, 16'h0000);
    push_cmd(OP_APPEND, 16'd40, 16'd1000, 16'h5555, 16'h0000);
    push_cmd(OP_APPEND, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd10);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd20);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd21);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd27);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd30);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd40);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd1000);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    push_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd10);
    // unsorted entries: the search follows its probe order regardless
    push_cmd(OP_APPEND, 16'd500, 16'd600, 16'h0A0A, 16'h0000);
    push_cmd(OP_APPEND, 16'd100, 16'd200, 16'h0B0B, 16'h0000);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd150);
    push_cmd(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'd550);
    wait_drained();

    // random phases with different idle patterns
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct = 6;
          recv_stall_pct = 6;
        end
      endcase
      phase_items = 0;
      if (p == 3) begin
        hold_left = 400;
      end
      // fill the table past its depth so appends get dropped
      if (p == 0 || p == 2) begin
        add_session(TBL_DEPTH, 4);
      end
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 12) begin
          add_noise();
        end else if ($urandom_range(99) < 6) begin
          add_session(0, 0);
        end else begin
          add_session($urandom_range(24, 1), 0);
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lookup_results_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, lookup_results_q.size());
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
